[sv/range_parity_count_tree_macros.svh]
// assertion macros for the range parity count tree
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef RANGE_PARITY_COUNT_TREE_MACROS_SVH
`define RANGE_PARITY_COUNT_TREE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication under synchronous active-low reset
`define RPCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpct: same-cycle check failed");
// next-cycle implication under synchronous active-low reset
`define RPCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpct: next-cycle check failed");
`else
`define RPCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/rpct_pkg.sv]
// shared types and constants for the range parity count tree
// no dependencies
package rpct_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int CNT_W = 11;
    localparam int POS_W = 10;
    localparam int VAL_W = 64;
    localparam int OP_W  = 2;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_EVEN = 2'd1;
    localparam logic [OP_W-1:0] OP_ODD  = 2'd2;

    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic upd_leaf;
        logic upd_rd;
        logic upd_sum;
        logic qry_init;
        logic qry_left;
        logic qry_right;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_set;
        logic is_qry;
        logic set_ok;
        logic qry_ok;
        logic upd_top;
        logic l_lt_r;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

[sv/rpct_dpath.sv]
// datapath: config register, tree memory, update walk, range sum and output register
// depends on rpct_pkg
module rpct_dpath import rpct_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CNT_W-1:0]        i_cfg_wr_data,
    input  logic [OP_W-1:0]         i_op,
    input  logic [POS_W-1:0]        i_first_position,
    input  logic [POS_W-1:0]        i_last_position,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [CNT_W-1:0]        o_count
);

    localparam int DEPTH   = 2 * CAPACITY;
    localparam int AW      = $clog2(DEPTH);
    localparam int IW      = AW + 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'((CAPACITY > CNT_MAX) ? CNT_MAX : CAPACITY);
    localparam logic [IW-1:0]    CAP_I   = IW'(CAPACITY);
    localparam logic [AW-1:0]    CAP_A   = AW'(CAPACITY);

    logic [CNT_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0] r_elem_cnt;
    logic [OP_W-1:0]  r_op;
    logic [POS_W-1:0] r_first;
    logic [POS_W-1:0] r_hi;
    logic [CNT_W-1:0] r_len;
    logic             r_odd;
    logic             r_set_ok;
    logic             r_qry_ok;
    logic [AW-1:0]    r_clr_idx;
    logic [AW-1:0]    r_node;
    logic [CNT_W-1:0] r_val;
    logic [IW-1:0]    r_l;
    logic [IW-1:0]    r_r;
    logic             r_pend;
    logic [CNT_W-1:0] r_acc;
    logic [CNT_W-1:0] r_rd_data;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;

    // item decode
    logic [CNT_W-1:0] eff_n, n_m1, first_x, last_x, hi_c, len_c;
    logic             set_ok_c, qry_ok_c;

    always_comb begin
        eff_n    = (r_elem_cnt > CAP_LIM) ? CAP_LIM : r_elem_cnt;
        n_m1     = eff_n - CNT_W'(1);
        first_x  = CNT_W'(i_first_position);
        last_x   = CNT_W'(i_last_position);
        hi_c     = (last_x < n_m1) ? last_x : n_m1;
        set_ok_c = first_x < eff_n;
        qry_ok_c = (eff_n != '0) && (first_x <= hi_c);
        len_c    = qry_ok_c ? (hi_c - first_x + CNT_W'(1)) : '0;
    end

    // memory port selection
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [CNT_W-1:0] wr_data, sum;
    logic [IW-1:0]    dec_r;

    always_comb begin
        sum     = r_val + r_rd_data;
        dec_r   = r_r - IW'(1);
        wr_en   = i_cmd.clr_wr | i_cmd.upd_leaf | i_cmd.upd_sum;
        wr_addr = r_clr_idx;
        wr_data = '0;
        if (i_cmd.upd_leaf) begin
            wr_addr = CAP_A + AW'(r_first);
            wr_data = CNT_W'(r_odd);
        end else if (i_cmd.upd_sum) begin
            wr_addr = r_node >> 1;
            wr_data = sum;
        end
        rd_en   = i_cmd.upd_rd | (i_cmd.qry_left & r_l[0]) | (i_cmd.qry_right & r_r[0]);
        rd_addr = r_node ^ AW'(1);
        if (i_cmd.qry_left) begin
            rd_addr = r_l[AW-1:0];
        end else if (i_cmd.qry_right) begin
            rd_addr = dec_r[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt  <= CNT_RESET;
            r_clr_idx   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_elem_cnt <= i_cfg_wr_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            r_pend <= (i_cmd.qry_left & r_l[0]) | (i_cmd.qry_right & r_r[0]);
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_first  <= i_first_position;
            r_hi     <= hi_c[POS_W-1:0];
            r_len    <= len_c;
            r_odd    <= i_new_value[0];
            r_set_ok <= set_ok_c;
            r_qry_ok <= qry_ok_c;
            r_acc    <= '0;
        end else if (r_pend) begin
            r_acc <= r_acc + r_rd_data;
        end
        if (i_cmd.upd_leaf) begin
            r_node <= CAP_A + AW'(r_first);
            r_val  <= CNT_W'(r_odd);
        end else if (i_cmd.upd_sum) begin
            r_node <= r_node >> 1;
            r_val  <= sum;
        end
        if (i_cmd.qry_init) begin
            r_l <= IW'(r_first) + CAP_I;
            r_r <= IW'(r_hi) + CAP_I + IW'(1);
        end else if (i_cmd.qry_left) begin
            if (r_l[0]) begin
                r_l <= r_l + IW'(1);
            end
        end else if (i_cmd.qry_right) begin
            r_l <= r_l >> 1;
            r_r <= (r_r[0] ? dec_r : r_r) >> 1;
        end
        if (i_cmd.out_load) begin
            r_count <= (r_op == OP_ODD) ? r_acc : (r_len - r_acc);
        end
    end

    always_comb begin
        o_sts.is_set   = (r_op == OP_SET);
        o_sts.is_qry   = (r_op == OP_EVEN) || (r_op == OP_ODD);
        o_sts.set_ok   = r_set_ok;
        o_sts.qry_ok   = r_qry_ok;
        o_sts.upd_top  = (r_node == AW'(1));
        o_sts.l_lt_r   = (r_l < r_r);
        o_sts.clr_last = (r_clr_idx == AW'(DEPTH - 1));
        o_sts.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid = r_out_valid;
    assign o_count = r_count;

endmodule

[sv/rpct_ctrl.sv]
// controller state machine: clearing pass, update walk and range sum sequencing
// depends on rpct_pkg and range_parity_count_tree_macros.svh
`include "range_parity_count_tree_macros.svh"

module rpct_ctrl import rpct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DECODE  = 4'd2;
    localparam logic [3:0] ST_U_LEAF  = 4'd3;
    localparam logic [3:0] ST_U_RD    = 4'd4;
    localparam logic [3:0] ST_U_SUM   = 4'd5;
    localparam logic [3:0] ST_Q_LEFT  = 4'd6;
    localparam logic [3:0] ST_Q_RIGHT = 4'd7;
    localparam logic [3:0] ST_OUT     = 4'd8;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (i_sts.is_set) begin
                    n_state = i_sts.set_ok ? ST_U_LEAF : ST_IDLE;
                end else if (i_sts.is_qry) begin
                    if (i_sts.qry_ok) begin
                        o_cmd.qry_init = 1'b1;
                        n_state        = ST_Q_LEFT;
                    end else begin
                        n_state = ST_OUT;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_U_LEAF: begin
                o_cmd.upd_leaf = 1'b1;
                n_state        = ST_U_RD;
            end
            ST_U_RD: begin
                if (i_sts.upd_top) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.upd_rd = 1'b1;
                    n_state      = ST_U_SUM;
                end
            end
            ST_U_SUM: begin
                o_cmd.upd_sum = 1'b1;
                n_state       = ST_U_RD;
            end
            ST_Q_LEFT: begin
                if (i_sts.l_lt_r) begin
                    o_cmd.qry_left = 1'b1;
                    n_state        = ST_Q_RIGHT;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_Q_RIGHT: begin
                o_cmd.qry_right = 1'b1;
                n_state         = ST_Q_LEFT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    `RPCT_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free)
    `RPCT_ASSERT_IMP(a_left_in_range, i_clk, i_rst_n, o_cmd.qry_left, i_sts.l_lt_r)
    `RPCT_ASSERT_IMP(a_sum_below_root, i_clk, i_rst_n, o_cmd.upd_sum, !i_sts.upd_top)
    `RPCT_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, o_cmd.capture, o_stall)

endmodule

[sv/range_parity_count_tree.sv]
// range parity count tree top level: controller plus datapath, depends on rpct_pkg
// a set beat walks from its leaf up to the root, reading each sibling on the way
// a count beat sums the range bottom-up, bounded by the one tree read port
// one beat is worked at a time; the next is taken while a result waits on the output
// synchronous active-low reset; afterwards a clearing pass zeroes the tree memory
// with o_stall held high, element count resets to 1024
module range_parity_count_tree import rpct_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration: element count
    input  logic                    i_cfg_wr_en,
    input  logic [CNT_W-1:0]        i_cfg_wr_data,
    // input beats
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [OP_W-1:0]         i_op,
    input  logic [POS_W-1:0]        i_first_position,
    input  logic [POS_W-1:0]        i_last_position,
    input  logic signed [VAL_W-1:0] i_new_value,
    // result beats
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [CNT_W-1:0]        o_count
);

    // the tree holds odd counts only: leaves at CAPACITY+position, node i sums
    // nodes 2i and 2i+1; an even count is the clipped range length minus the odd count
    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing: clearing pass, leaf-to-root update walk, bottom-up range sum
    rpct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // storage and arithmetic: tree memory with one write and one registered read port
    rpct_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_op             (i_op),
        .i_first_position (i_first_position),
        .i_last_position  (i_last_position),
        .i_new_value      (i_new_value),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_count          (o_count)
    );

endmodule

[tb/sv/rpct_tb_pkg.sv]
// parity tracking scoreboard for the range parity count tree testbench
// depends on rpct_pkg for field widths, op codes and the reset element count
package rpct_tb_pkg;

    import rpct_pkg::*;

    // op code 3 is left unused by the block
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    class parity_count_tracker;

        bit             odd_marks [CAPACITY_DEF];
        bit [CNT_W-1:0] element_count;
        bit [CNT_W-1:0] due_counts [$];
        int             failures;

        function new();
            element_count = CNT_RESET;
            failures      = 0;
        endfunction

        function void set_element_count(bit [CNT_W-1:0] count_value);
            element_count = count_value;
        endfunction

        // positions actually in use, never above capacity
        function int in_use();
            return (element_count < CAPACITY_DEF) ? int'(element_count) : CAPACITY_DEF;
        endfunction

        // note an accepted input beat and queue the count it must give
        function void note_beat(bit [OP_W-1:0] op, bit [POS_W-1:0] first_pos,
                                bit [POS_W-1:0] last_pos, bit [VAL_W-1:0] new_value);
            int n;
            int lo;
            int hi;
            int odd_sum;
            bit [CNT_W-1:0] want;
            n  = in_use();
            lo = int'(first_pos);
            case (op)
                OP_SET: begin
                    if (lo < n)
                        odd_marks[lo] = new_value[0];
                end
                OP_EVEN, OP_ODD: begin
                    want = '0;
                    if (n > 0) begin
                        hi = (int'(last_pos) < n - 1) ? int'(last_pos) : n - 1;
                        if (lo <= hi) begin
                            odd_sum = 0;
                            for (int p = lo; p <= hi; p++)
                                odd_sum += int'(odd_marks[p]);
                            want = (op == OP_ODD) ? CNT_W'(odd_sum)
                                                  : CNT_W'((hi - lo + 1) - odd_sum);
                        end
                    end
                    due_counts.push_back(want);
                end
                default: begin
                    // unused op: no state change, no count
                end
            endcase
        endfunction

        // compare one accepted count beat with the oldest expectation
        function void check_count(bit [CNT_W-1:0] seen);
            bit [CNT_W-1:0] want;
            if (due_counts.size() == 0) begin
                $display("%0t: count beat with none expected, expected none, actual %0d",
                         $time, seen);
                failures++;
            end else begin
                want = due_counts.pop_front();
                if (want != seen) begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, want, seen);
                    failures++;
                end
            end
        endfunction

        function int pending();
            return due_counts.size();
        endfunction

        function void drop_leftover();
            $display("%0t: counts never delivered, expected %0d more, actual 0",
                     $time, due_counts.size());
            failures++;
            due_counts.delete();
        endfunction

    endclass

endpackage

[tb/sv/range_parity_count_tree_tb.sv]
// top-level testbench for range_parity_count_tree: random and directed set and count beats
// depends on rpct_pkg and on rpct_tb_pkg for the parity tracking scoreboard
module range_parity_count_tree_tb;

    import rpct_pkg::*;
    import rpct_tb_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CNT_W-1:0]        i_cfg_wr_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [OP_W-1:0]         i_op;
    logic [POS_W-1:0]        i_first_position;
    logic [POS_W-1:0]        i_last_position;
    logic signed [VAL_W-1:0] i_new_value;
    logic                    o_valid;
    logic                    i_stall;
    logic [CNT_W-1:0]        o_count;

    // shared scoreboard: input side notes beats, output side checks counts
    parity_count_tracker tracker = new();

    // when set, the input side sends back to back with no gaps
    bit sender_steady;

    range_parity_count_tree dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_first_position (i_first_position),
        .i_last_position  (i_last_position),
        .i_new_value      (i_new_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_count          (o_count)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // hard stop well beyond the slowest legal run
    initial begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

    // gap before the next input beat: mostly none or short, now and then long
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (sender_steady)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // offer one input beat, hold it until taken, then maybe idle
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [POS_W-1:0] first_pos,
                             input logic [POS_W-1:0] last_pos,
                             input logic [VAL_W-1:0] new_value);
        int gap;
        i_valid          <= 1'b1;
        i_op             <= op;
        i_first_position <= first_pos;
        i_last_position  <= last_pos;
        i_new_value      <= new_value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        tracker.note_beat(op, first_pos, last_pos, new_value);
        gap = gap_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // element count register write, only with the block idle
    task automatic write_element_count(input logic [CNT_W-1:0] count_value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count_value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.set_element_count(count_value);
    endtask

    // mostly well-formed ranges inside the positions in use, some anywhere
    task automatic random_beats(input int num);
        int n;
        int r;
        int first_pos;
        int last_pos;
        logic [OP_W-1:0] op;
        n = tracker.in_use();
        repeat (num) begin
            if ($urandom_range(0, 99) == 0)
                sender_steady = !sender_steady;
            r  = $urandom_range(0, 99);
            op = (r < 45) ? OP_SET : (r < 70) ? OP_EVEN : (r < 95) ? OP_ODD : OP_UNUSED;
            if (n > 0 && $urandom_range(0, 9) < 8) begin
                first_pos = $urandom_range(0, n - 1);
                if ($urandom_range(0, 3) == 0)
                    last_pos = first_pos + $urandom_range(0, 7);
                else
                    last_pos = $urandom_range(first_pos, n - 1);
                if (last_pos > 1023)
                    last_pos = 1023;
            end else begin
                // anywhere in the field: sets beyond the count, inverted and clipped ranges
                first_pos = $urandom_range(0, 1023);
                last_pos  = $urandom_range(0, 1023);
            end
            send_beat(op, first_pos[POS_W-1:0], last_pos[POS_W-1:0], {$urandom, $urandom});
        end
    endtask

    // drop valid, wait for every count, then let a trailing set finish
    task automatic settle();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (tracker.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (64) @(posedge i_clk);
        if (tracker.pending() != 0)
            tracker.drop_leftover();
    endtask

    // output side: random stalls, quiet stretches, and two long hold-offs
    initial begin : count_sink
        int taken;
        int hold_left;
        int stall_left;
        int quiet_left;
        int holds_done;
        int r;
        bit next_stall;
        i_stall    = 1'b0;
        taken      = 0;
        hold_left  = 0;
        stall_left = 0;
        quiet_left = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                tracker.check_count(o_count);
                taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_stall = 1'b1;
            end else if (holds_done < 2 && taken >= ((holds_done == 0) ? 40 : 700)) begin
                // long hold-off so the block fills and pushes back on the input
                holds_done++;
                hold_left  = 400;
                next_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                next_stall = 1'b1;
            end else if (quiet_left > 0) begin
                quiet_left--;
                next_stall = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    quiet_left = $urandom_range(50, 200);
                    next_stall = 1'b0;
                end else if (r < 60) begin
                    next_stall = 1'b0;
                end else if (r < 92) begin
                    stall_left = $urandom_range(0, 2);
                    next_stall = 1'b1;
                end else begin
                    stall_left = $urandom_range(15, 60);
                    next_stall = 1'b1;
                end
            end
            i_stall <= next_stall;
        end
    end

    // input side and run control
    initial begin : beat_source
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        i_valid          = 1'b0;
        i_op             = OP_SET;
        i_first_position = '0;
        i_last_position  = '0;
        i_new_value      = '0;
        sender_steady    = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block clears its tree after reset with the input stalled
        repeat (2) @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);

        // reset element count: whole array, all even after the clearing pass
        send_beat(OP_EVEN, 10'd0, 10'd1023, 64'd0);
        send_beat(OP_ODD, 10'd0, 10'd1023, 64'd0);
        send_beat(OP_SET, 10'd0, 10'd0, 64'd1);
        send_beat(OP_SET, 10'd1023, 10'd0, '1);
        send_beat(OP_SET, 10'd512, 10'd1023, 64'h8000_0000_0000_0000);
        send_beat(OP_SET, 10'd5, 10'd0, 64'h7fff_ffff_ffff_ffff);
        send_beat(OP_SET, 10'd6, 10'd0, 64'd0);
        send_beat(OP_ODD, 10'd0, 10'd1023, 64'd0);
        send_beat(OP_EVEN, 10'd0, 10'd1023, '1);
        // inverted range gives zero
        send_beat(OP_ODD, 10'd10, 10'd3, 64'd0);
        send_beat(OP_ODD, 10'd1023, 10'd1023, 64'd0);
        send_beat(OP_EVEN, 10'd0, 10'd0, 64'd0);
        // unused op is dropped without a count
        send_beat(OP_UNUSED, 10'd1023, 10'd1023, '1);
        send_beat(OP_ODD, 10'd0, 10'd6, 64'd0);
        random_beats(300);
        settle();

        // smallest count: one position, set beyond it ignored, ranges clipped
        write_element_count(11'd1);
        send_beat(OP_SET, 10'd0, 10'd0, 64'd0);
        send_beat(OP_SET, 10'd1, 10'd0, 64'd1);
        send_beat(OP_ODD, 10'd0, 10'd1023, 64'd0);
        send_beat(OP_EVEN, 10'd1, 10'd5, 64'd0);
        random_beats(40);
        settle();

        // zero count: every set ignored, every count zero
        write_element_count(11'd0);
        send_beat(OP_SET, 10'd0, 10'd0, 64'd1);
        send_beat(OP_EVEN, 10'd0, 10'd1023, 64'd0);
        send_beat(OP_ODD, 10'd0, 10'd0, 64'd0);
        random_beats(20);
        settle();

        // count above capacity behaves as full capacity; old marks reappear
        write_element_count(11'd2047);
        send_beat(OP_ODD, 10'd0, 10'd1023, 64'd0);
        send_beat(OP_EVEN, 10'd1000, 10'd1023, 64'd0);
        random_beats(300);
        settle();

        write_element_count(11'd37);
        random_beats(300);
        settle();

        write_element_count(11'd700);
        random_beats(300);
        settle();

        write_element_count(11'd1024);
        random_beats(300);
        settle();

        write_element_count(11'd513);
        random_beats(200);
        settle();

        if (tracker.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/rpct_pkg.sv
sv/rpct_dpath.sv
sv/rpct_ctrl.sv
sv/range_parity_count_tree.sv
tb/sv/rpct_tb_pkg.sv
tb/sv/range_parity_count_tree_tb.sv
